// File: rtl/core/lfrb_pkg.sv
// ----------------------------------------------------------------------------
// lfrb_pkg
// Types and constants shared by the replicated-border image filter.
// ----------------------------------------------------------------------------
package lfrb_pkg;

    localparam int MAX_HEIGHT     = 64;
    localparam int MAX_WIDTH      = 64;
    localparam int MAX_RADIUS     = 3;
    localparam int COEF_FRAC_BITS = 12;
    localparam int KSIDE          = 2 * MAX_RADIUS + 1;
    localparam int KDEPTH         = KSIDE * KSIDE;
    localparam int FDEPTH         = MAX_HEIGHT * MAX_WIDTH;
    localparam int RW             = $clog2(MAX_HEIGHT);
    localparam int CW             = $clog2(MAX_WIDTH);
    localparam int FAW            = $clog2(FDEPTH);
    localparam int KAW            = $clog2(KDEPTH);
    localparam int KW             = $clog2(KSIDE);
    localparam int ACC_W          = 16 + 8 + 6 + 1;
    localparam int Q_DEPTH        = 2;

    localparam logic [1:0] OP_COEF    = 2'd0;
    localparam logic [1:0] OP_PIXEL   = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam logic [1:0] REG_HEIGHT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [2:0]         coef_row;
        logic [2:0]         coef_col;
        logic signed [15:0] coef_value;
        logic [5:0]         pixel_row;
        logic [5:0]         pixel_col;
        logic [7:0]         pixel_value;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_pixel;
        logic [5:0] out_row;
        logic [5:0] out_col;
        logic       frame_done;
    } out_word_t;

    // job handed from front to back: one output position and frame geometry
    typedef struct packed {
        logic [RW-1:0] row;
        logic [CW-1:0] col;
        logic [RW:0]   h;
        logic [CW:0]   w;
        logic [1:0]    r;
        logic          last;
    } job_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } q_ctl_t;

endpackage

// File: rtl/core/log_filter_replicate_border.sv
// ----------------------------------------------------------------------------
// log_filter_replicate_border
// Square-kernel image filter with border replication.
// ----------------------------------------------------------------------------
// Usage: raise start with a command word on cmd; it is taken at an edge where
// busy is low. Load coefficients (op 0) and pixels (op 1) are written straight
// into the kernel and frame RAMs. A compute word (op 2) is queued and walked by
// one shared multiply-accumulate reading the frame RAM once per tap. The result
// word appears on result for one cycle with done high; the receiver cannot stall
// it. busy is high while a job is queued or in flight, so loads never race a
// walk. Configuration is written through cfg_we / cfg_index / cfg_data while
// idle. Reset restores height 64, width 64, radius 1 and restarts the raster at
// row 0, column 0; frame and kernel RAMs hold garbage until loaded.
// ----------------------------------------------------------------------------
module log_filter_replicate_border (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  lfrb_pkg::in_word_t  cmd,
    output logic                busy,
    output logic                done,
    output lfrb_pkg::out_word_t result,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [6:0]          cfg_data
);

    logic [6:0] height_reg, width_reg;
    logic [1:0] radius_reg;
    logic pix_we, coef_we, job_push, pop, active;
    logic [lfrb_pkg::FAW-1:0] pix_addr, f_raddr;
    logic [lfrb_pkg::KAW-1:0] coef_addr, k_raddr;
    logic [7:0] pix_data, f_rdata;
    logic [15:0] coef_data, k_rdata;
    lfrb_pkg::job_t job_in, job_out;
    lfrb_pkg::q_ctl_t qctl;

    assign busy = active || !qctl.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= 7'd64;
            width_reg  <= 7'd64;
            radius_reg <= 2'd1;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    lfrb_pkg::REG_HEIGHT: height_reg <= cfg_data;
                    lfrb_pkg::REG_WIDTH:  width_reg <= cfg_data;
                    lfrb_pkg::REG_RADIUS: radius_reg <= cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    lfrb_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd), .busy(busy),
        .image_height(height_reg), .image_width(width_reg),
        .kernel_radius(radius_reg),
        .pix_we(pix_we), .pix_addr(pix_addr), .pix_data(pix_data),
        .coef_we(coef_we), .coef_addr(coef_addr), .coef_data(coef_data),
        .job_push(job_push), .job(job_in)
    );

    lfrb_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(job_push), .din(job_in),
        .pop(pop), .ctl(qctl), .dout(job_out)
    );

    lfrb_ram #(.WIDTH(8), .DEPTH(lfrb_pkg::FDEPTH)) u_frame (
        .clk(clk), .we(pix_we), .waddr(pix_addr), .wdata(pix_data),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    lfrb_ram #(.WIDTH(16), .DEPTH(lfrb_pkg::KDEPTH)) u_kernel (
        .clk(clk), .we(coef_we), .waddr(coef_addr), .wdata(coef_data),
        .raddr(k_raddr), .rdata(k_rdata)
    );

    lfrb_back u_back (
        .clk(clk), .rst_n(rst_n), .qctl(qctl), .job(job_out), .pop(pop),
        .f_raddr(f_raddr), .f_rdata(f_rdata), .k_raddr(k_raddr), .k_rdata(k_rdata),
        .done(done), .result(result), .active(active)
    );

endmodule

// File: rtl/core/lfrb_ram.sv
// ----------------------------------------------------------------------------
// lfrb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/lfrb_front.sv
// ----------------------------------------------------------------------------
// lfrb_front
// Accepts commands, filters loads by size, tracks the raster walk, queues jobs.
// ----------------------------------------------------------------------------
module lfrb_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  lfrb_pkg::in_word_t cmd,
    input  logic              busy,
    input  logic [6:0]        image_height,
    input  logic [6:0]        image_width,
    input  logic [1:0]        kernel_radius,
    output logic              pix_we,
    output logic [lfrb_pkg::FAW-1:0] pix_addr,
    output logic [7:0]        pix_data,
    output logic              coef_we,
    output logic [lfrb_pkg::KAW-1:0] coef_addr,
    output logic [15:0]       coef_data,
    output logic              job_push,
    output lfrb_pkg::job_t    job
);

    logic [lfrb_pkg::RW:0] h;
    logic [lfrb_pkg::CW:0] w;
    logic [1:0]            r;
    logic [lfrb_pkg::RW-1:0] row_reg, row_next, cur_row;
    logic [lfrb_pkg::CW-1:0] col_reg, col_next, cur_col;
    logic                  acc, outside, last;

    always_comb
    begin
        // sizes saturate to 1..max, zero acts as one
        if (image_height == 7'd0) h = 7'd1;
        else if (image_height > 7'(lfrb_pkg::MAX_HEIGHT)) h = 7'(lfrb_pkg::MAX_HEIGHT);
        else h = image_height;
        if (image_width == 7'd0) w = 7'd1;
        else if (image_width > 7'(lfrb_pkg::MAX_WIDTH)) w = 7'(lfrb_pkg::MAX_WIDTH);
        else w = image_width;
        r = kernel_radius;
        acc = start && !busy;
        outside = ({1'b0, row_reg} >= h) || ({1'b0, col_reg} >= w);
        cur_row = outside ? '0 : row_reg;
        cur_col = outside ? '0 : col_reg;
        last = ({1'b0, cur_row} == h - 7'd1) && ({1'b0, cur_col} == w - 7'd1);
        row_next = row_reg;
        col_next = col_reg;
        job_push = acc && (cmd.op == lfrb_pkg::OP_COMPUTE);
        if (job_push)
        begin
            if (last)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if ({1'b0, cur_col} + 7'd1 >= w)
            begin
                col_next = '0;
                row_next = cur_row + 1'b1;
            end
            else
            begin
                row_next = cur_row;
                col_next = cur_col + 1'b1;
            end
        end
        job = '{row: cur_row, col: cur_col, h: h, w: w, r: r, last: last};

        pix_we = acc && (cmd.op == lfrb_pkg::OP_PIXEL)
                 && ({1'b0, cmd.pixel_row} < h) && ({1'b0, cmd.pixel_col} < w);
        pix_addr = {cmd.pixel_row, cmd.pixel_col};
        pix_data = cmd.pixel_value;
        coef_we = acc && (cmd.op == lfrb_pkg::OP_COEF)
                  && ({1'b0, cmd.coef_row} <= {r, 1'b0})
                  && ({1'b0, cmd.coef_col} <= {r, 1'b0});
        coef_addr = lfrb_pkg::KAW'(cmd.coef_row * lfrb_pkg::KSIDE + cmd.coef_col);
        coef_data = cmd.coef_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

// File: rtl/core/lfrb_queue.sv
// ----------------------------------------------------------------------------
// lfrb_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module lfrb_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lfrb_pkg::job_t    din,
    input  logic              pop,
    output lfrb_pkg::q_ctl_t  ctl,
    output lfrb_pkg::job_t    dout
);

    lfrb_pkg::job_t slot_reg [lfrb_pkg::Q_DEPTH];
    logic [$clog2(lfrb_pkg::Q_DEPTH)-1:0] wp_reg, rp_reg;
    logic [$clog2(lfrb_pkg::Q_DEPTH):0]   cnt_reg;

    assign ctl.push  = push;
    assign ctl.pop   = pop;
    assign ctl.empty = (cnt_reg == '0);
    assign ctl.full  = (cnt_reg == ($clog2(lfrb_pkg::Q_DEPTH) + 1)'(lfrb_pkg::Q_DEPTH));
    assign dout      = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
        end
    end

endmodule

// File: rtl/core/lfrb_back.sv
// ----------------------------------------------------------------------------
// lfrb_back
// Walks the window with one shared multiply-accumulate and emits the result.
// ----------------------------------------------------------------------------
module lfrb_back (
    input  logic              clk,
    input  logic              rst_n,
    input  lfrb_pkg::q_ctl_t  qctl,
    input  lfrb_pkg::job_t    job,
    output logic              pop,
    output logic [lfrb_pkg::FAW-1:0] f_raddr,
    input  logic [7:0]        f_rdata,
    output logic [lfrb_pkg::KAW-1:0] k_raddr,
    input  logic [15:0]       k_rdata,
    output logic              done,
    output lfrb_pkg::out_word_t result,
    output logic              active
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_TAP  = 5'b00010,
        S_MUL  = 5'b00100,
        S_CTR  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    lfrb_pkg::job_t job_reg;
    logic [lfrb_pkg::KW-1:0] k_reg, l_reg;
    logic issue_reg;
    logic signed [lfrb_pkg::ACC_W-1:0] acc_reg;
    logic signed [24:0] prod_reg;
    logic prod_v_reg;
    logic signed [lfrb_pkg::ACC_W-1:0] val;
    logic signed [lfrb_pkg::ACC_W-1:0] mag;
    logic signed [7:0] dk, dl;
    logic signed [8:0] x, y;
    logic [lfrb_pkg::RW-1:0] xr;
    logic [lfrb_pkg::CW-1:0] yc;
    logic tap_end;

    assign active = (state_reg != S_IDLE);
    assign pop = (state_reg == S_IDLE) && !qctl.empty;

    always_comb
    begin
        dk = $signed({5'd0, k_reg}) - $signed({6'd0, job_reg.r});
        dl = $signed({5'd0, l_reg}) - $signed({6'd0, job_reg.r});
        x = $signed({3'd0, job_reg.row}) + 9'(dk);
        y = $signed({3'd0, job_reg.col}) + 9'(dl);
        if (x < 0) xr = '0;
        else if (x >= $signed({2'd0, job_reg.h})) xr = lfrb_pkg::RW'(job_reg.h - 7'd1);
        else xr = x[lfrb_pkg::RW-1:0];
        if (y < 0) yc = '0;
        else if (y >= $signed({2'd0, job_reg.w})) yc = lfrb_pkg::CW'(job_reg.w - 7'd1);
        else yc = y[lfrb_pkg::CW-1:0];
        if (state_reg == S_CTR) f_raddr = {job_reg.row, job_reg.col};
        else f_raddr = {xr, yc};
        k_raddr = lfrb_pkg::KAW'(k_reg * lfrb_pkg::KSIDE + l_reg);
        tap_end = (k_reg == {job_reg.r, 1'b0}) && (l_reg == {job_reg.r, 1'b0});
        // truncate toward zero
        mag = acc_reg[lfrb_pkg::ACC_W-1] ? -acc_reg : acc_reg;
        val = mag >>> lfrb_pkg::COEF_FRAC_BITS;
        if (acc_reg[lfrb_pkg::ACC_W-1]) val = -val;
        val = val - $signed({23'd0, f_rdata});
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (!qctl.empty) state_next = S_TAP;
            S_TAP:  if (tap_end) state_next = S_MUL;
            S_MUL:  if (!issue_reg && !prod_v_reg) state_next = S_CTR;
            S_CTR:  state_next = S_OUT;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop) job_reg <= job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            k_reg      <= '0;
            l_reg      <= '0;
            issue_reg  <= 1'b0;
            prod_v_reg <= 1'b0;
            prod_reg   <= '0;
            acc_reg    <= '0;
            done       <= 1'b0;
            result     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done <= 1'b0;
            // RAM read data and then the product are registered; issue_reg and prod_v_reg mark them valid
            issue_reg  <= (state_reg == S_TAP);
            prod_v_reg <= issue_reg;
            prod_reg   <= $signed(k_rdata) * $signed({1'b0, f_rdata});
            if (prod_v_reg) acc_reg <= acc_reg + lfrb_pkg::ACC_W'(prod_reg);
            if (pop)
            begin
                k_reg   <= '0;
                l_reg   <= '0;
                acc_reg <= '0;
            end
            else if (state_reg == S_TAP)
            begin
                if (l_reg == {job_reg.r, 1'b0})
                begin
                    l_reg <= '0;
                    k_reg <= k_reg + 1'b1;
                end
                else
                begin
                    l_reg <= l_reg + 1'b1;
                end
            end
            if (state_reg == S_OUT)
            begin
                done <= 1'b1;
                if (val < 0) result.out_pixel <= 8'd0;
                else if (val > 255) result.out_pixel <= 8'd255;
                else result.out_pixel <= val[7:0];
                result.out_row <= 6'(job_reg.row);
                result.out_col <= 6'(job_reg.col);
                result.frame_done <= job_reg.last;
            end
        end
    end

endmodule

// File: rtl/core/lfrb_checker.sv
// ----------------------------------------------------------------------------
// lfrb_checker
// Port-level checks on the filter's command and result channels.
// ----------------------------------------------------------------------------
module lfrb_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input lfrb_pkg::in_word_t  cmd,
    input logic                busy,
    input logic                done
);

    // a compute word always makes the block busy next cycle
    a_busy_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.op == lfrb_pkg::OP_COMPUTE) |=> busy)
        else $error("busy not raised after compute");

    // result strobe is never held: done drops after each strobe
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held");

    // a result only follows a busy cycle
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done while idle");

endmodule

bind log_filter_replicate_border lfrb_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd), .busy(busy), .done(done)
);
